// ----- sv/sdt_pkg.sv -----
package sdt_pkg;

    // Framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Message types that carry a channel number in payload byte four
    localparam logic [7:0] MSG_TYPE_A = 8'h0F;
    localparam logic [7:0] MSG_TYPE_B = 8'h03;

    // Channel number coding: SDCCH/4 is 001SSTTT, SDCCH/8 is 01SSSTTT
    localparam logic [7:0] SDCCH4_MASK = 8'hE0;
    localparam logic [7:0] SDCCH4_CODE = 8'h20;
    localparam logic [7:0] SDCCH8_MASK = 8'hC0;
    localparam logic [7:0] SDCCH8_CODE = 8'h40;

    // Reset values
    localparam logic [7:0] SEL_CHANNEL_RESET  = 8'd5;
    localparam logic [7:0] LAST_CHANNEL_RESET = 8'hFF;

    // Channel kinds
    localparam logic KIND_SDCCH4 = 1'b0;
    localparam logic KIND_SDCCH8 = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_ESC
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [8:0]  frame_length;
        logic        chan_report;
        logic        chan_kind;
        logic [2:0]  chan_subslot;
        logic [2:0]  chan_timeslot;
        logic [7:0]  chan_number;
        logic [31:0] report_seq;
    } result_t;

endpackage

// ----- sv/sdt_in_reg.sv -----
module sdt_in_reg
    import sdt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // The register takes a new byte when empty or when its byte moves on.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            data_next  = s_rx_byte;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// ----- sv/sdt_parser.sv -----
module sdt_parser
    import sdt_pkg::*;
#(
    parameter int BUFFER_BYTES = 512
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       advance,
    input  logic [7:0] byte_data,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = (CW > 9) ? CW : 9;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    sel_reg;
    logic [7:0]    sel_next;
    logic [7:0]    chan_id_reg;
    logic [7:0]    chan_id_next;
    logic [7:0]    msg_type_reg;
    logic [7:0]    msg_type_next;
    logic [7:0]    chan_byte_reg;
    logic [7:0]    chan_byte_next;
    logic [7:0]    last_chan_reg;
    logic [7:0]    last_chan_next;
    logic [31:0]   report_cnt_reg;
    logic [31:0]   report_cnt_next;

    logic          is_flag;
    logic          is_esc;
    logic          take;
    logic          close;
    logic [7:0]    data_byte;
    logic [PW-1:0] plen;
    logic          is_sdcch4;
    logic          is_sdcch8;
    logic          want_report;

    // Byte classification
    assign is_flag   = (byte_data == FLAG_BYTE);
    assign is_esc    = (byte_data == ESC_BYTE);
    assign data_byte = (state_reg == ST_ESC) ? (byte_data ^ ESC_XOR) : byte_data;
    assign take      = advance && ((state_reg == ST_ESC) ||
                       ((state_reg == ST_FRAME) && !is_flag && !is_esc));
    assign close     = advance && (state_reg == ST_FRAME) && is_flag;

    // Payload length and channel number decoding for the closing flag
    assign plen        = PW'(count_reg) - PW'(2);
    assign is_sdcch4   = ((chan_byte_reg & SDCCH4_MASK) == SDCCH4_CODE);
    assign is_sdcch8   = ((chan_byte_reg & SDCCH8_MASK) == SDCCH8_CODE);
    assign want_report = ((msg_type_reg == MSG_TYPE_A) || (msg_type_reg == MSG_TYPE_B))
                         && (plen >= PW'(5)) && (is_sdcch4 || is_sdcch8)
                         && (chan_byte_reg != last_chan_reg);

    // Next parse state
    always_comb begin
        state_next = state_reg;
        if (advance) begin
            case (state_reg)
                ST_IDLE: begin
                    if (is_flag) begin
                        state_next = ST_FRAME;
                    end
                end
                ST_FRAME: begin
                    if (is_esc) begin
                        state_next = ST_ESC;
                    end
                end
                ST_ESC: begin
                    state_next = ST_FRAME;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Frame bookkeeping, channel tracking and the result
    always_comb begin
        count_next      = count_reg;
        sel_next        = cfg_write ? cfg_data : sel_reg;
        chan_id_next    = chan_id_reg;
        msg_type_next   = msg_type_reg;
        chan_byte_next  = chan_byte_reg;
        last_chan_next  = last_chan_reg;
        report_cnt_next = report_cnt_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (advance && (state_reg == ST_IDLE) && is_flag) begin
            count_next = '0;
        end

        if (take && (count_reg < CW'(BUFFER_BYTES))) begin
            count_next = count_reg + CW'(1);
            if (count_reg == CW'(0)) begin
                chan_id_next = data_byte;
            end
            if (count_reg == CW'(2)) begin
                msg_type_next = data_byte;
            end
            if (count_reg == CW'(6)) begin
                chan_byte_next = data_byte;
            end
            if ((count_reg >= CW'(2)) && (chan_id_reg == sel_reg)) begin
                res_valid    = 1'b1;
                res.out_byte = data_byte;
            end
        end

        if (close) begin
            count_next = '0;
            if ((count_reg > CW'(2)) && (chan_id_reg == sel_reg)) begin
                res_valid        = 1'b1;
                res.frame_end    = 1'b1;
                res.frame_length = plen[8:0];
                if (want_report) begin
                    last_chan_next    = chan_byte_reg;
                    report_cnt_next   = report_cnt_reg + 32'd1;
                    res.chan_report   = 1'b1;
                    res.chan_kind     = is_sdcch4 ? KIND_SDCCH4 : KIND_SDCCH8;
                    res.chan_subslot  = is_sdcch4 ? {1'b0, chan_byte_reg[4:3]}
                                                  : chan_byte_reg[5:3];
                    res.chan_timeslot = chan_byte_reg[2:0];
                    res.chan_number   = chan_byte_reg;
                    res.report_seq    = report_cnt_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            sel_reg        <= SEL_CHANNEL_RESET;
            chan_id_reg    <= '0;
            msg_type_reg   <= '0;
            chan_byte_reg  <= '0;
            last_chan_reg  <= LAST_CHANNEL_RESET;
            report_cnt_reg <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sel_reg        <= sel_next;
            chan_id_reg    <= chan_id_next;
            msg_type_reg   <= msg_type_next;
            chan_byte_reg  <= chan_byte_next;
            last_chan_reg  <= last_chan_next;
            report_cnt_reg <= report_cnt_next;
        end
    end

    // A channel report only ever rides on an end marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.chan_report |-> res.frame_end)
        else $error("channel report without end marker");

    // The report count steps by one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (report_cnt_reg != $past(report_cnt_reg))
        |-> (report_cnt_reg == $past(report_cnt_reg) + 32'd1))
        else $error("report count jumped");

    // The last channel only changes together with a report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (last_chan_reg != $past(last_chan_reg))
        |-> $past(res_valid && res.chan_report))
        else $error("last channel changed without report");

    // An escaped byte always returns the parser to the frame state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(advance) && ($past(state_reg) == ST_ESC)
        |-> (state_reg == ST_FRAME))
        else $error("parser did not leave escape state");

endmodule

// ----- sv/sdt_out_reg.sv -----
module sdt_out_reg
    import sdt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    // Free when empty or when the held result leaves in this cycle.
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- sv/sercomm_deframer_channel_tracker.sv -----
// Serial frame deframer with dedicated-channel tracker.
//
// Input channel (s_valid, s_ready, s_rx_byte) takes one raw line byte per
// transfer. Output channel (m_valid, m_ready, m_*) gives decoded payload
// bytes of frames on the selected channel, then one end marker carrying the
// payload length and, where a new SDCCH/4 or SDCCH/8 channel number was seen,
// a channel report. A byte produces at most one result.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// selected channel id; it is always ready and should be used while idle.
// An input byte passes through the input register, then through the parser
// into the output register; a stall on the output holds it in between.
// Throughput is one byte per cycle while the receiver does not stall the
// output register.
// Reset clears the parser to wait for an opening flag, selects channel 5,
// sets the last channel to 0xFF and the report count to zero.
// When the receiver stalls, the output register holds its result, the input
// register still takes one more byte, and s_ready then drops until m_ready.
module sercomm_deframer_channel_tracker
    import sdt_pkg::*;
#(
    parameter int BUFFER_BYTES = 512
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end,
    output logic [8:0]  m_frame_length,
    output logic        m_chan_report,
    output logic        m_chan_kind,
    output logic [2:0]  m_chan_subslot,
    output logic [2:0]  m_chan_timeslot,
    output logic [7:0]  m_chan_number,
    output logic [31:0] m_report_seq
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       can_load;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    m_data;

    // A byte moves on when the output register can take its result.
    assign advance   = byte_valid && can_load;
    assign cfg_ready = 1'b1;

    sdt_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sdt_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    sdt_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_data (res),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Result fields onto their ports
    assign m_out_byte      = m_data.out_byte;
    assign m_frame_end     = m_data.frame_end;
    assign m_frame_length  = m_data.frame_length;
    assign m_chan_report   = m_data.chan_report;
    assign m_chan_kind     = m_data.chan_kind;
    assign m_chan_subslot  = m_data.chan_subslot;
    assign m_chan_timeslot = m_data.chan_timeslot;
    assign m_chan_number   = m_data.chan_number;
    assign m_report_seq    = m_data.report_seq;

endmodule

// ----- bench/sdt_deframe_checker.sv -----
`timescale 1ns / 1ps

module sdt_deframe_checker
    import sdt_pkg::*;
#(
    parameter int BUF_BYTES = 512
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_frame_end,
    input  logic [8:0]  m_frame_length,
    input  logic        m_chan_report,
    input  logic        m_chan_kind,
    input  logic [2:0]  m_chan_subslot,
    input  logic [2:0]  m_chan_timeslot,
    input  logic [7:0]  m_chan_number,
    input  logic [31:0] m_report_seq,
    output int          pending,
    output int          err_count
);

    // Shadow of the deframer state, advanced on every input transfer.
    parse_state_t pstate;
    int unsigned  kept;
    logic [7:0]   sel_chan;
    logic [7:0]   frame_chan;
    logic [7:0]   msg_type;
    logic [7:0]   chan_byte;
    logic [7:0]   last_chan;
    logic [31:0]  report_cnt;
    int unsigned  results_seen;

    // Decoded results still waiting to come out of the block, oldest first.
    result_t      decoded_q[$];

    initial begin
        err_count    = 0;
        pending      = 0;
        results_seen = 0;
    end

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at time %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
        end
    endtask

    // A decoded frame byte: the first is the channel id, the second the control
    // byte, and the rest are payload, passed on only for the selected channel.
    task automatic keep_frame_byte(input logic [7:0] b);
        int unsigned idx;
        result_t     r;
        idx = kept;
        if (idx < BUF_BYTES) begin
            kept = idx + 1;
            if (idx == 0) begin
                frame_chan = b;
            end else if (idx >= 2) begin
                if (idx == 2) msg_type = b;
                if (idx == 6) chan_byte = b;
                if (frame_chan == sel_chan) begin
                    r          = '0;
                    r.out_byte = b;
                    decoded_q.push_back(r);
                end
            end
        end
    endtask

    // Closing flag: end marker with the payload length and, where a new
    // dedicated channel number turned up, a channel report.
    task automatic close_frame_marker();
        int unsigned plen;
        result_t     r;
        logic        is_ded;
        logic        kind;
        logic [2:0]  sub;
        if (kept > 2 && frame_chan == sel_chan) begin
            plen           = kept - 2;
            r              = '0;
            r.frame_end    = 1'b1;
            r.frame_length = 9'(plen);
            if ((msg_type == MSG_TYPE_A || msg_type == MSG_TYPE_B) && plen >= 5) begin
                is_ded = 1'b0;
                kind   = KIND_SDCCH4;
                sub    = '0;
                if ((chan_byte & SDCCH4_MASK) == SDCCH4_CODE) begin
                    is_ded = 1'b1;
                    kind   = KIND_SDCCH4;
                    sub    = {1'b0, chan_byte[4:3]};
                end else if ((chan_byte & SDCCH8_MASK) == SDCCH8_CODE) begin
                    is_ded = 1'b1;
                    kind   = KIND_SDCCH8;
                    sub    = chan_byte[5:3];
                end
                if (is_ded && chan_byte != last_chan) begin
                    last_chan       = chan_byte;
                    report_cnt      = report_cnt + 1;
                    r.chan_report   = 1'b1;
                    r.chan_kind     = kind;
                    r.chan_subslot  = sub;
                    r.chan_timeslot = chan_byte[2:0];
                    r.chan_number   = chan_byte;
                    r.report_seq    = report_cnt;
                end
            end
            decoded_q.push_back(r);
        end
    endtask

    // Byte-level parser: flags, escapes and the wait for the first flag.
    task automatic deframe_byte(input logic [7:0] b);
        case (pstate)
            ST_IDLE: begin
                if (b == FLAG_BYTE) begin
                    pstate = ST_FRAME;
                    kept   = 0;
                end
            end
            ST_FRAME: begin
                if (b == FLAG_BYTE) begin
                    if (kept > 0) close_frame_marker();
                    kept = 0;
                end else if (b == ESC_BYTE) begin
                    pstate = ST_ESC;
                end else begin
                    keep_frame_byte(b);
                end
            end
            ST_ESC: begin
                keep_frame_byte(b ^ ESC_XOR);
                pstate = ST_FRAME;
            end
            default: begin
                pstate = ST_IDLE;
            end
        endcase
    endtask

    // Watch all three channels; results are compared before the same edge's
    // input transfer is predicted.
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            pstate     = ST_IDLE;
            kept       = 0;
            sel_chan   = SEL_CHANNEL_RESET;
            frame_chan = '0;
            msg_type   = '0;
            chan_byte  = '0;
            last_chan  = LAST_CHANNEL_RESET;
            report_cnt = '0;
            decoded_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", 32'(m_out_byte), 32'(want.out_byte));
                    check_field("frame_end", 32'(m_frame_end), 32'(want.frame_end));
                    check_field("frame_length", 32'(m_frame_length),
                                32'(want.frame_length));
                    check_field("chan_report", 32'(m_chan_report),
                                32'(want.chan_report));
                    check_field("chan_kind", 32'(m_chan_kind), 32'(want.chan_kind));
                    check_field("chan_subslot", 32'(m_chan_subslot),
                                32'(want.chan_subslot));
                    check_field("chan_timeslot", 32'(m_chan_timeslot),
                                32'(want.chan_timeslot));
                    check_field("chan_number", 32'(m_chan_number),
                                32'(want.chan_number));
                    check_field("report_seq", m_report_seq, want.report_seq);
                end
            end
            if (cfg_valid && cfg_ready) begin
                sel_chan = cfg_data;
            end
            if (s_valid && s_ready) begin
                deframe_byte(s_rx_byte);
            end
        end
        pending <= decoded_q.size();
    end

endmodule

// ----- bench/sercomm_deframer_channel_tracker_tb.sv -----
`timescale 1ns / 1ps

module sercomm_deframer_channel_tracker_tb
    import sdt_pkg::*;
();

    localparam int BUF_BYTES   = 512;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_frame_end;
    logic [8:0]  m_frame_length;
    logic        m_chan_report;
    logic        m_chan_kind;
    logic [2:0]  m_chan_subslot;
    logic [2:0]  m_chan_timeslot;
    logic [7:0]  m_chan_number;
    logic [31:0] m_report_seq;

    int          pending;
    int          err_count;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          tx_gap_pct  = 0;
    int          rx_stall_pct = 0;
    int          stall_left  = 0;
    logic [7:0]  cur_sel     = SEL_CHANNEL_RESET;
    logic [7:0]  prev_cnum   = 8'h20;

    always #6 aclk = ~aclk;

    sercomm_deframer_channel_tracker #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_length (m_frame_length),
        .m_chan_report  (m_chan_report),
        .m_chan_kind    (m_chan_kind),
        .m_chan_subslot (m_chan_subslot),
        .m_chan_timeslot(m_chan_timeslot),
        .m_chan_number  (m_chan_number),
        .m_report_seq   (m_report_seq)
    );

    sdt_deframe_checker #(
        .BUF_BYTES(BUF_BYTES)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_length (m_frame_length),
        .m_chan_report  (m_chan_report),
        .m_chan_kind    (m_chan_kind),
        .m_chan_subslot (m_chan_subslot),
        .m_chan_timeslot(m_chan_timeslot),
        .m_chan_number  (m_chan_number),
        .m_report_seq   (m_report_seq),
        .pending        (pending),
        .err_count      (err_count)
    );

    // Watchdog: a run that hangs or loses results ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver back-pressure: m_ready drops in stall bursts of random length.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One line byte per transfer, sometimes after a gap of random length.
    task automatic push_byte(input logic [7:0] b);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send a decoded byte, escaping it where needed and now and then anyway.
    task automatic put_decoded(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0) begin
            push_byte(ESC_BYTE);
            push_byte(b ^ ESC_XOR);
        end else begin
            push_byte(b);
        end
    endtask

    // A well-formed frame of n_dec decoded bytes (channel id and control
    // included) with a message type and channel number at their offsets.
    task automatic send_frame(input logic [7:0] chan, input int n_dec);
        logic [7:0] mtype;
        logic [7:0] cnum;
        int         pick;
        int         d;
        pick = $urandom_range(0, 99);
        if (pick < 40) mtype = MSG_TYPE_A;
        else if (pick < 70) mtype = MSG_TYPE_B;
        else mtype = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) cnum = prev_cnum;
        else if (pick < 55) cnum = SDCCH4_CODE | 8'($urandom_range(0, 31));
        else if (pick < 85) cnum = SDCCH8_CODE | 8'($urandom_range(0, 63));
        else cnum = 8'($urandom);
        prev_cnum = cnum;
        if ($urandom_range(0, 1) == 1) push_byte(FLAG_BYTE);
        for (d = 0; d < n_dec; d++) begin
            if (d == 0) put_decoded(chan);
            else if (d == 2) put_decoded(mtype);
            else if (d == 6) put_decoded(cnum);
            else put_decoded(8'($urandom));
        end
        push_byte(FLAG_BYTE);
    endtask

    // Raw line noise, rich in flags and escapes, to break frames apart.
    task automatic send_noise();
        int pick;
        repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) push_byte(FLAG_BYTE);
            else if (pick == 1) push_byte(ESC_BYTE);
            else push_byte(8'($urandom));
        end
    endtask

    // Hold the sender until every result is out and the pipeline has emptied.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Reselect the channel while the block is idle.
    task automatic write_sel(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_sel = v;
    endtask

    initial begin
        logic [7:0] sel_plan [5];
        int         ph;
        int         target;
        logic [7:0] chan;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, on the channel selected at reset.
        tx_gap_pct   = 25;
        rx_stall_pct = 15;
        // Bytes before the first flag are ignored, then back-to-back flags.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(FLAG_BYTE);
        push_byte(FLAG_BYTE);
        // SDCCH/4 report; a flag right after an escape is data.
        push_byte(8'h05);
        push_byte(8'h00);
        push_byte(MSG_TYPE_A);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ESC_BYTE);
        push_byte(FLAG_BYTE);
        push_byte(8'h2B);
        push_byte(ESC_BYTE);
        push_byte(8'h5E);
        push_byte(FLAG_BYTE);
        // SDCCH/8 report with an escaped escape byte in the payload.
        push_byte(8'h05);
        push_byte(8'h01);
        push_byte(MSG_TYPE_B);
        push_byte(ESC_BYTE);
        push_byte(8'h5D);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h53);
        push_byte(FLAG_BYTE);
        // The selected channel changes while a frame is open.
        push_byte(8'h05);
        push_byte(8'h00);
        push_byte(MSG_TYPE_A);
        push_byte(8'h11);
        write_sel(8'hFF);
        push_byte(8'h22);
        push_byte(FLAG_BYTE);

        // Random part: one channel setting per phase, the first and last without gaps or stalls.
        sel_plan[0] = 8'h00;
        sel_plan[1] = 8'hFF;
        sel_plan[2] = SEL_CHANNEL_RESET;
        sel_plan[3] = 8'($urandom);
        sel_plan[4] = 8'($urandom);
        for (ph = 0; ph < 5; ph++) begin
            if (ph == 0 || ph == 4) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = 10 * ph;
                rx_stall_pct = 5 * ph + 5;
            end
            write_sel(sel_plan[ph]);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if ($urandom_range(0, 99) < 85) begin
                    chan = ($urandom_range(0, 3) != 0) ? cur_sel : 8'($urandom);
                    if ($urandom_range(0, 99) < 15) send_frame(chan, $urandom_range(1, 3));
                    else send_frame(chan, $urandom_range(4, 16));
                end else begin
                    send_noise();
                end
            end
        end
        // Overlong frame: the payload length saturates.
        push_byte(FLAG_BYTE);
        send_frame(cur_sel, BUF_BYTES + 5);

        drain();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
